[hdl/csvfs_pkg.sv]
// csvfs_pkg: request and result types, codes and fixed sizes of the csv field splitter
// no dependencies; imported by every module of the block
package csvfs_pkg;

    localparam int MAX_RES   = 5;
    localparam int HOLD_DEPTH = 3;

    localparam logic [1:0] CFG_SEP_BYTES  = 2'd0;
    localparam logic [1:0] CFG_SEP_LENGTH = 2'd1;
    localparam logic [1:0] CFG_QUOTE_BYTE = 2'd2;
    localparam logic [1:0] CFG_QUOTE_EN   = 2'd3;

    localparam logic [1:0] KIND_BYTE       = 2'd0;
    localparam logic [1:0] KIND_FIELD_END  = 2'd1;
    localparam logic [1:0] KIND_RECORD_END = 2'd2;

    localparam logic [1:0] MODE_OUT   = 2'd0;
    localparam logic [1:0] MODE_IN    = 2'd1;
    localparam logic [1:0] MODE_AFTER = 2'd2;

    localparam logic       CMD_TEXT = 1'b0;
    localparam logic       CMD_EOL  = 1'b1;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    typedef struct packed {
        logic       command;
        logic [7:0] text_byte;
        logic       final_line;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] field_byte;
        logic       last_of_run;
    } t_out;

    typedef struct packed {
        logic [31:0] sep_bytes;
        logic [2:0]  sep_length;
        logic [7:0]  quote_byte;
        logic        quote_en;
    } t_cfg;

    typedef struct packed {
        logic [1:0]                  mode;
        logic [1:0]                  held_cnt;
        logic [HOLD_DEPTH-1:0][7:0]  held;
    } t_state;

endpackage

[hdl/csvfs_step.sv]
// csvfs_step: combinational tokenizer step, one request against the current state
// produces up to five results and the next state; uses csvfs_pkg
module csvfs_step
    import csvfs_pkg::*;
#(
    parameter int MAX_SEPARATOR = 4
) (
    input  t_in    i_in,
    input  t_cfg   i_cfg,
    input  t_state i_state,
    output t_out   o_res [MAX_RES],
    output logic [2:0] o_cnt,
    output t_state o_state
);

    logic [7:0] b [8];
    logic [2:0] len;
    logic [2:0] pos;
    logic [2:0] rem;
    logic [2:0] k;
    logic [2:0] eff;
    logic [2:0] idx;
    logic [2:0] n;
    logic [1:0] mode;
    logic       stop;
    logic       hit;
    logic       eol;
    logic       is_quote;
    logic [7:0] c;

    always_comb begin
        eff = i_cfg.sep_length;
        if (eff == 3'd0) eff = 3'd1;
        if (int'(eff) > MAX_SEPARATOR) eff = 3'(MAX_SEPARATOR);
        if (eff > 3'd4) eff = 3'd4;
    end

    always_comb begin
        eol = (i_in.command == CMD_EOL);
        for (int j = 0; j < 8; j++) begin
            b[j] = 8'd0;
        end
        len = 3'd0;
        for (int j = 0; j < HOLD_DEPTH; j++) begin
            if (3'(j) < {1'b0, i_state.held_cnt}) begin
                b[j] = i_state.held[j];
                len  = len + 3'd1;
            end
        end
        if (!eol) begin
            b[len] = i_in.text_byte;
            len    = len + 3'd1;
        end

        for (int j = 0; j < MAX_RES; j++) begin
            o_res[j] = '0;
        end
        n        = 3'd0;
        pos      = 3'd0;
        stop     = 1'b0;
        rem      = 3'd0;
        k        = 3'd0;
        idx      = 3'd0;
        hit      = 1'b0;
        is_quote = 1'b0;
        c        = 8'd0;
        o_state          = i_state;
        o_state.held_cnt = 2'd0;
        mode = (i_state.mode == MODE_IN || i_state.mode == MODE_AFTER) ? i_state.mode : MODE_OUT;

        for (int it = 0; it < 4; it++) begin
            if (!stop && pos < len) begin
                rem = len - pos;
                hit = 1'b0;
                if (mode != MODE_IN) begin
                    k   = (rem < eff) ? rem : eff;
                    hit = 1'b1;
                    for (int j = 0; j < 4; j++) begin
                        idx = pos + 3'(j);
                        if (3'(j) < k && b[idx] != i_cfg.sep_bytes[j*8 +: 8]) hit = 1'b0;
                    end
                    if (hit && rem >= eff) begin
                        if (n < 3'(MAX_RES)) begin
                            o_res[n] = '{kind: KIND_FIELD_END, field_byte: 8'd0, last_of_run: 1'b0};
                        end
                        n    = n + 3'd1;
                        mode = MODE_OUT;
                        pos  = pos + eff;
                    end else if (hit && !eol) begin
                        for (int j = 0; j < HOLD_DEPTH; j++) begin
                            idx = pos + 3'(j);
                            o_state.held[j] = b[idx];
                        end
                        o_state.held_cnt = rem[1:0];
                        stop = 1'b1;
                    end else begin
                        hit = 1'b0;
                    end
                end
                if (!hit && !stop) begin
                    c        = b[pos];
                    is_quote = i_cfg.quote_en && (c == i_cfg.quote_byte);
                    case (mode)
                        MODE_IN: begin
                            if (is_quote) begin
                                mode = MODE_AFTER;
                            end else begin
                                if (n < 3'(MAX_RES)) begin
                                    o_res[n] = '{kind: KIND_BYTE, field_byte: c, last_of_run: 1'b0};
                                end
                                n = n + 3'd1;
                            end
                        end
                        MODE_AFTER: begin
                            if (n < 3'(MAX_RES)) begin
                                o_res[n] = '{kind: KIND_BYTE, field_byte: c, last_of_run: 1'b0};
                            end
                            n    = n + 3'd1;
                            mode = is_quote ? MODE_IN : MODE_OUT;
                        end
                        default: begin
                            if (is_quote) begin
                                mode = MODE_IN;
                            end else begin
                                if (n < 3'(MAX_RES)) begin
                                    o_res[n] = '{kind: KIND_BYTE, field_byte: c, last_of_run: 1'b0};
                                end
                                n    = n + 3'd1;
                                mode = MODE_OUT;
                            end
                        end
                    endcase
                    pos = pos + 3'd1;
                end
            end
        end

        if (eol) begin
            if (n < 3'(MAX_RES)) begin
                if (mode == MODE_IN && !i_in.final_line) begin
                    o_res[n] = '{kind: KIND_BYTE, field_byte: NEWLINE_BYTE, last_of_run: 1'b0};
                end else begin
                    o_res[n] = '{kind: KIND_RECORD_END, field_byte: 8'd0, last_of_run: 1'b0};
                end
            end
            if (!(mode == MODE_IN && !i_in.final_line)) mode = MODE_OUT;
            n = n + 3'd1;
        end

        for (int j = 0; j < MAX_RES; j++) begin
            o_res[j].last_of_run = (n != 3'd0) && (3'(j) == n - 3'd1);
        end
        o_cnt        = n;
        o_state.mode = mode;
    end

endmodule

[hdl/csvfs_out_buf.sv]
// csvfs_out_buf: result register of one step, drained one result per cycle while i_stall is low
// loads a full run of results when empty or finishing; uses csvfs_pkg
module csvfs_out_buf
    import csvfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_out       i_res [MAX_RES],
    input  logic [2:0] i_cnt,
    output logic       o_ready,
    output logic       o_valid,
    output t_out       o_data,
    input  logic       i_stall
);

    t_out       r_res [MAX_RES];
    logic [2:0] r_cnt;
    logic [2:0] r_pos;
    logic       deliver;
    logic       finishing;

    assign o_valid   = (r_cnt != 3'd0);
    assign o_data    = r_res[r_pos];
    assign deliver   = o_valid && !i_stall;
    assign finishing = deliver && (r_pos == r_cnt - 3'd1);
    assign o_ready   = !o_valid || finishing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_pos <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_cnt;
            r_pos <= 3'd0;
        end else if (finishing) begin
            r_cnt <= 3'd0;
            r_pos <= 3'd0;
        end else if (deliver) begin
            r_pos <= r_pos + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    a_load_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_ready)
        else $error("result run loaded while previous run still pending");

    a_pos_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_pos < r_cnt))
        else $error("read position beyond run length");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (deliver && o_data.last_of_run && !i_load) |=> !o_valid)
        else $error("run continues after last result");

endmodule

[hdl/csv_field_splitter_core.sv]
// csv_field_splitter_core: top level of the csv field splitter
// holds configuration, request register and tokenizer state; uses csvfs_pkg, csvfs_step, csvfs_out_buf
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------
//  request  | in        | i_in_valid / o_in_stall   | i_in  (t_in)
//  result   | out       | o_out_valid / i_out_stall | o_out (t_out)
//  config   | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// a request waits in the input register until the result register can take it, then the whole step
// runs into the result register; each request yields up to five results at the result port;
// requests whose step yields nothing give no result but still pass through the input register
// synchronous active-low reset restores the default config and clears mode and held count
// a stall on the result side backs up into o_in_stall once the input register is occupied
module csv_field_splitter_core
    import csvfs_pkg::*;
#(
    parameter int MAX_SEPARATOR = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg       r_cfg;
    t_state     r_state;
    t_state     n_state;
    t_in        r_in;
    logic       r_in_valid;
    t_out       step_res [MAX_RES];
    logic [2:0] step_cnt;
    logic       buf_ready;
    logic       adv;
    logic       in_acc;

    assign adv        = r_in_valid && buf_ready;
    assign o_in_stall = r_in_valid && !buf_ready;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sep_bytes  <= 32'd44;
            r_cfg.sep_length <= 3'd1;
            r_cfg.quote_byte <= 8'd34;
            r_cfg.quote_en   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEP_BYTES:  r_cfg.sep_bytes  <= i_cfg_data;
                CFG_SEP_LENGTH: r_cfg.sep_length <= i_cfg_data[2:0];
                CFG_QUOTE_BYTE: r_cfg.quote_byte <= i_cfg_data[7:0];
                CFG_QUOTE_EN:   r_cfg.quote_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
        end
    end

    // held bytes need no reset, only the count gates them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode     <= MODE_OUT;
            r_state.held_cnt <= 2'd0;
        end else if (adv) begin
            r_state.mode     <= n_state.mode;
            r_state.held_cnt <= n_state.held_cnt;
            r_state.held     <= n_state.held;
        end
    end

    csvfs_step #(
        .MAX_SEPARATOR(MAX_SEPARATOR)
    ) u_step (
        .i_in    (r_in),
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .o_res   (step_res),
        .o_cnt   (step_cnt),
        .o_state (n_state)
    );

    csvfs_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv),
        .i_res   (step_res),
        .i_cnt   (step_cnt),
        .o_ready (buf_ready),
        .o_valid (o_out_valid),
        .o_data  (o_out),
        .i_stall (i_out_stall)
    );

    a_eol_clears_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.command == CMD_EOL) |=> (r_state.held_cnt == 2'd0))
        else $error("held separator bytes survive a line end");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out.last_of_run) |=> o_out_valid)
        else $error("result run broken before its last result");

    a_eol_yields_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in.command == CMD_EOL) |=> o_out_valid)
        else $error("line end produced no result");

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> (r_state.mode == MODE_OUT || r_state.mode == MODE_IN
                 || r_state.mode == MODE_AFTER))
        else $error("quote mode left its legal codes");

endmodule

[tb/csv_field_splitter_core_test.sv]
`timescale 1ns / 1ps
// csv_field_splitter_core_test: self-checking testbench of the csv field splitter core
// depends on csvfs_pkg and csv_field_splitter_core; tokenizes every accepted request on its own
// and compares each result with the oldest expected token
module csv_field_splitter_core_test;
    import csvfs_pkg::*;

    localparam int MAX_SEP      = 4;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in         in_req = '0;
    logic        out_valid;
    logic        recv_stall = 1'b0;
    logic        hold_off = 1'b0;
    logic        hold_request = 1'b0;
    wire         out_stall = recv_stall | hold_off;
    t_out        out_tok;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    bit          sender_gaps = 1'b1;
    bit          receiver_gaps = 1'b1;
    int          sent_count = 0;
    int          mismatch_count = 0;
    int          result_count = 0;

    t_cfg        tok_cfg;
    logic [1:0]  tok_mode;
    logic [7:0]  tok_held [0:HOLD_DEPTH-1];
    logic [1:0]  tok_held_cnt;
    t_out        step_tokens [$];
    t_out        expected_tokens [$];

    csv_field_splitter_core #(.MAX_SEPARATOR(MAX_SEP)) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_tok),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic t_cfg make_cfg(logic [31:0] sep, logic [2:0] len, logic [7:0] q,
                                      logic qen);
        t_cfg c;
        c.sep_bytes  = sep;
        c.sep_length = len;
        c.quote_byte = q;
        c.quote_en   = qen;
        return c;
    endfunction

    function automatic t_in make_req(logic cmd, logic [7:0] b, logic fin);
        t_in r;
        r.command    = cmd;
        r.text_byte  = b;
        r.final_line = fin;
        return r;
    endfunction

    function automatic int sep_len_eff();
        int n;
        n = tok_cfg.sep_length;
        if (n == 0) n = 1;
        if (n > MAX_SEP) n = MAX_SEP;
        if (n > 4) n = 4;
        return n;
    endfunction

    function automatic logic [7:0] sep_byte(int i);
        return tok_cfg.sep_bytes[8 * (i % 4) +: 8];
    endfunction

    task automatic emit_token(logic [1:0] kind, logic [7:0] b);
        t_out t;
        t.kind        = kind;
        t.field_byte  = b;
        t.last_of_run = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic plain_text_byte(logic [7:0] c);
        bit is_quote;
        is_quote = tok_cfg.quote_en && (c == tok_cfg.quote_byte);
        case (tok_mode)
            MODE_IN: begin
                if (is_quote) tok_mode = MODE_AFTER;
                else emit_token(KIND_BYTE, c);
            end
            MODE_AFTER: begin
                emit_token(KIND_BYTE, c);
                tok_mode = is_quote ? MODE_IN : MODE_OUT;
            end
            default: begin
                if (is_quote) begin
                    tok_mode = MODE_IN;
                end else begin
                    emit_token(KIND_BYTE, c);
                    tok_mode = MODE_OUT;
                end
            end
        endcase
    endtask

    task automatic tokenize_request(t_in req);
        logic [7:0] pend [0:3];
        int         len;
        int         pos;
        int         rem;
        int         k;
        int         eff;
        int         i;
        bit         eol;
        bit         hit;
        bit         handled;
        t_out       t;
        eff = sep_len_eff();
        eol = (req.command == CMD_EOL);
        len = 0;
        for (i = 0; i < tok_held_cnt; i++) begin
            pend[len] = tok_held[i];
            len++;
        end
        if (!eol) begin
            pend[len] = req.text_byte;
            len++;
        end
        tok_held_cnt = '0;
        if (tok_mode > MODE_AFTER) tok_mode = MODE_OUT;
        step_tokens.delete();
        pos = 0;
        while (pos < len) begin
            rem = len - pos;
            handled = 1'b0;
            if (tok_mode != MODE_IN) begin
                k = (rem < eff) ? rem : eff;
                hit = 1'b1;
                for (i = 0; i < k; i++)
                    if (pend[pos + i] != sep_byte(i)) hit = 1'b0;
                if (hit && rem >= eff) begin
                    emit_token(KIND_FIELD_END, 8'h00);
                    tok_mode = MODE_OUT;
                    pos += eff;
                    handled = 1'b1;
                end else if (hit && !eol) begin
                    for (i = 0; i < rem; i++) tok_held[i] = pend[pos + i];
                    tok_held_cnt = rem[1:0];
                    pos = len;
                    handled = 1'b1;
                end
            end
            if (!handled) begin
                plain_text_byte(pend[pos]);
                pos++;
            end
        end
        if (eol) begin
            if (tok_mode == MODE_IN && !req.final_line) begin
                emit_token(KIND_BYTE, NEWLINE_BYTE);
            end else begin
                emit_token(KIND_RECORD_END, 8'h00);
                tok_mode = MODE_OUT;
            end
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
        foreach (step_tokens[j]) begin
            t = step_tokens[j];
            expected_tokens.push_back(t);
        end
    endtask

    task automatic send_request(t_in req);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_req   = req;
        do @(posedge clk); while (in_stall);
        tokenize_request(req);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_request(make_req(CMD_TEXT, b, 1'($urandom_range(0, 1))));
    endtask

    task automatic send_eol(logic fin);
        send_request(make_req(CMD_EOL, 8'($urandom_range(0, 255)), fin));
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (expected_tokens.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_regs(t_cfg c);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_index = CFG_SEP_BYTES;
        cfg_data  = c.sep_bytes;
        @(negedge clk);
        cfg_index = CFG_SEP_LENGTH;
        cfg_data  = {29'd0, c.sep_length};
        @(negedge clk);
        cfg_index = CFG_QUOTE_BYTE;
        cfg_data  = {24'd0, c.quote_byte};
        @(negedge clk);
        cfg_index = CFG_QUOTE_EN;
        cfg_data  = {31'd0, c.quote_en};
        @(negedge clk);
        cfg_we  = 1'b0;
        tok_cfg = c;
    endtask

    function automatic logic [7:0] pick_content();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(0, 255));
            1: return sep_byte($urandom_range(0, sep_len_eff() - 1));
            default: return 8'h61 + 8'($urandom_range(0, 2));
        endcase
    endfunction

    task automatic send_record();
        int nfields;
        int nb;
        int i;
        nfields = $urandom_range(1, 3);
        for (int f = 0; f < nfields; f++) begin
            if (f > 0)
                for (i = 0; i < sep_len_eff(); i++) send_byte(sep_byte(i));
            nb = $urandom_range(0, 4);
            if (tok_cfg.quote_en && $urandom_range(0, 1)) begin
                send_byte(tok_cfg.quote_byte);
                for (i = 0; i < nb; i++) begin
                    case ($urandom_range(0, 7))
                        0: begin
                            send_byte(tok_cfg.quote_byte);
                            send_byte(tok_cfg.quote_byte);
                        end
                        1: send_eol(1'b0);
                        default: send_byte(pick_content());
                    endcase
                end
                send_byte(tok_cfg.quote_byte);
                if ($urandom_range(0, 3) == 0) send_byte(pick_content());
            end else begin
                for (i = 0; i < nb; i++) send_byte(pick_content());
            end
        end
        send_eol(1'($urandom_range(0, 3) == 0));
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n)
            send_request(make_req(($urandom_range(0, 7) == 0) ? CMD_EOL : CMD_TEXT,
                                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
    endtask

    task automatic test_quoted_fields();
        send_text("a,\"b\"\"c\"d");
        send_eol(1'b0);
        send_text("\"");
        send_eol(1'b0);
        send_eol(1'b1);
    endtask

    task automatic test_byte_extremes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_request(make_req(CMD_EOL, 8'hFF, 1'b1));
    endtask

    task automatic test_multibyte_separator();
        write_regs(make_cfg(32'h0000_3B3A, 3'd2, 8'h22, 1'b1));
        send_text("::;:");
        send_eol(1'b0);
    endtask

    task automatic test_reconfig_while_held();
        write_regs(make_cfg(32'h0063_6261, 3'd3, 8'h22, 1'b1));
        send_text("ab");
        write_regs(make_cfg(32'h0063_6261, 3'd1, 8'h22, 1'b1));
        send_text("c");
        send_eol(1'b1);
    endtask

    task automatic test_random_records();
        t_cfg phases [0:4];
        int   target;
        phases[0] = make_cfg(32'h0000_002C, 3'd1, 8'h22, 1'b1);
        phases[1] = make_cfg(32'h0000_0000, 3'd4, 8'hFF, 1'b1);
        phases[2] = make_cfg(32'hFFFF_FFFF, 3'd7, 8'h00, 1'b1);
        phases[3] = make_cfg($urandom, 3'd0, 8'($urandom_range(0, 255)), 1'b0);
        phases[4] = make_cfg($urandom, 3'($urandom_range(2, 3)),
                             8'($urandom_range(0, 255)), 1'b1);
        for (int p = 0; p < 5; p++) begin
            write_regs(phases[p]);
            sender_gaps   = (p != 2);
            receiver_gaps = (p != 2);
            target = sent_count + 16;
            while (sent_count < target) begin
                if ($urandom_range(0, 4) != 0) send_record();
                else send_noise();
            end
        end
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    task automatic test_result_backpressure();
        write_regs(make_cfg(32'h0000_002C, 3'd1, 8'h22, 1'b1));
        sender_gaps  = 1'b0;
        hold_request = 1'b1;
        repeat (4) send_record();
        sender_gaps = 1'b1;
        wait_drained();
        hold_request = 1'b0;
    endtask

    initial begin
        forever begin
            @(posedge hold_request);
            hold_off = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_off = 1'b0;
        end
    end

    initial begin
        int n;
        forever begin
            n = receiver_gaps ? $urandom_range(0, 14) : 0;
            if (n > 0) begin
                recv_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            recv_stall = 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            @(negedge clk);
        end
    end

    always @(posedge clk) begin
        t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_tokens.size() == 0) begin
                if (mismatch_count < 10)
                    $display("result %0d unexpected: kind %0d byte %02h last %0b",
                             result_count, out_tok.kind, out_tok.field_byte,
                             out_tok.last_of_run);
                mismatch_count++;
            end else begin
                want = expected_tokens.pop_front();
                if (out_tok.kind !== want.kind || out_tok.field_byte !== want.field_byte ||
                    out_tok.last_of_run !== want.last_of_run) begin
                    if (mismatch_count < 10) begin
                        $write("result %0d: expected kind %0d byte %02h last %0b, ",
                               result_count, want.kind, want.field_byte, want.last_of_run);
                        $display("got kind %0d byte %02h last %0b",
                                 out_tok.kind, out_tok.field_byte, out_tok.last_of_run);
                    end
                    mismatch_count++;
                end
            end
            result_count++;
        end
    end

    initial begin
        #5_000_000;
        $display("csv_field_splitter_core: mismatch");
        $finish;
    end

    initial begin
        tok_cfg      = make_cfg(32'h0000_002C, 3'd1, 8'h22, 1'b1);
        tok_mode     = MODE_OUT;
        tok_held_cnt = '0;
        foreach (tok_held[i]) tok_held[i] = 8'h00;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_quoted_fields();
        test_byte_extremes();
        test_multibyte_separator();
        test_reconfig_while_held();
        test_random_records();
        test_result_backpressure();
        wait_drained();
        if (expected_tokens.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("csv_field_splitter_core: match");
        end else begin
            $display("csv_field_splitter_core: mismatch");
        end
        $finish;
    end

endmodule
